// ===== sv/afi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the ARMA forecaster.
package afi_pkg;
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_AR   = 2'd1;
  localparam logic [1:0] OP_MA   = 2'd2;
  localparam logic [1:0] OP_FC   = 2'd3;

  localparam logic [2:0] REG_AR_ORDER  = 3'd0;
  localparam logic [2:0] REG_MA_ORDER  = 3'd1;
  localparam logic [2:0] REG_DIFF      = 3'd2;
  localparam logic [2:0] REG_INTERCEPT = 3'd3;
  localparam logic [2:0] REG_VARIANCE  = 3'd4;
  localparam logic [2:0] REG_HORIZON   = 3'd5;
  localparam logic [2:0] REG_MODE      = 3'd6;

  localparam logic [1:0] MODE_99 = 2'd1;
  localparam logic [1:0] MODE_90 = 2'd2;

  localparam logic [17:0] Z_95 = 18'd128451;
  localparam logic [17:0] Z_99 = 18'd168821;
  localparam logic [17:0] Z_90 = 18'd107807;

  typedef struct packed {
    logic push;
    logic wr_ar;
    logic wr_ma;
    logic fc_init;
    logic mac_ar;
    logic mac_ma;
    logic sqrt_start;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tap_done;
    logic sqrt_done;
    logic step_last;
    logic hz_zero;
  } sts_t;
endpackage

// ===== sv/afi_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the ARMA forecaster.
module afi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     operation_i,
  input  afi_pkg::sts_t  sts_i,
  output afi_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_AR   = 6'b000010,
    S_MA   = 6'b000100,
    S_SQRT = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   go;

  assign go = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.push  = (operation_i == afi_pkg::OP_PUSH);
          cmd_o.wr_ar = (operation_i == afi_pkg::OP_AR);
          cmd_o.wr_ma = (operation_i == afi_pkg::OP_MA);
          if (operation_i == afi_pkg::OP_FC) begin
            cmd_o.fc_init = 1'b1;
            if (!sts_i.hz_zero) state_d = S_AR;
          end
        end
      end
      S_AR: begin
        cmd_o.mac_ar = 1'b1;
        if (sts_i.tap_done) state_d = S_MA;
      end
      S_MA: begin
        cmd_o.mac_ma = 1'b1;
        if (sts_i.tap_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = sts_i.step_last ? S_IDLE : S_AR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && operation_i != afi_pkg::OP_FC |=> state_q == S_IDLE)
    else $error("cheap request left idle");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> $past(state_q) == S_FIN)
    else $error("emit without finish");
endmodule

// ===== sv/afi_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the ARMA forecaster: histories, taps, MAC, root and bounds.
module afi_dp #(
  parameter int MAX_AR = 16,
  parameter int MAX_MA = 16,
  parameter int MAX_HORIZON = 64,
  parameter int MAX_DIFF = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afi_pkg::cmd_t       cmd_i,
  output afi_pkg::sts_t       sts_o,
  input  logic [3:0]          tap_index_i,
  input  logic signed [31:0]  sample_value_i,
  input  logic signed [31:0]  sample_residual_i,
  input  logic [4:0]          ar_order_i,
  input  logic [4:0]          ma_order_i,
  input  logic [1:0]          diff_order_i,
  input  logic signed [31:0]  intercept_i,
  input  logic [31:0]         noise_variance_i,
  input  logic [6:0]          horizon_i,
  input  logic [1:0]          confidence_mode_i,
  output logic signed [31:0]  prediction_o,
  output logic signed [31:0]  lower_bound_o,
  output logic signed [31:0]  upper_bound_o,
  output logic [5:0]          step_ahead_o,
  output logic                last_o,
  output logic                result_valid_o
);
  localparam int AW = $clog2(MAX_AR + 1);
  localparam int MW = $clog2(MAX_MA + 1);
  localparam int HW = $clog2(MAX_HORIZON + 1);
  localparam int DW = $clog2(MAX_DIFF + 1);
  localparam int TW = (AW > MW) ? AW : MW;
  localparam int ACW = 48 + TW + 1;

  logic signed [31:0] ar_q [MAX_AR];
  logic signed [31:0] ma_q [MAX_MA];
  logic signed [31:0] vh_q [MAX_AR];
  logic signed [31:0] rh_q [MAX_MA];
  logic signed [31:0] sc_q [MAX_AR];
  logic signed [31:0] dm_q [MAX_DIFF];
  logic [DW-1:0]      warm_q;
  logic [HW-1:0]      step_q, hz_q;
  logic [AW-1:0]      p_q;
  logic [MW-1:0]      q_q;
  logic [TW-1:0]      j_q;
  logic signed [ACW-1:0] acc_q;
  logic signed [31:0] pred_q;
  logic [17:0]        z_q;

  // differencing chain
  logic signed [31:0] lv [MAX_DIFF+1];
  logic [DW-1:0]      dsel;
  always_comb begin
    lv[0] = sample_value_i;
    for (int k = 0; k < MAX_DIFF; k++) begin
      logic signed [32:0] t;
      t = 33'(lv[k]) - 33'(dm_q[k]);
      lv[k+1] = (t > 33'sd2147483647) ? 32'sh7fffffff :
                (t < -33'sd2147483648) ? 32'sh80000000 : t[31:0];
    end
    dsel = (32'(diff_order_i) > MAX_DIFF) ? DW'(MAX_DIFF) : DW'(diff_order_i);
  end

  logic [AW-1:0] p_c;
  logic [MW-1:0] q_c;
  logic [HW-1:0] hz_c;
  assign p_c  = (32'(ar_order_i) > MAX_AR) ? AW'(MAX_AR) : AW'(ar_order_i);
  assign q_c  = (32'(ma_order_i) > MAX_MA) ? MW'(MAX_MA) : MW'(ma_order_i);
  assign hz_c = (32'(horizon_i) > MAX_HORIZON) ? HW'(MAX_HORIZON) : HW'(horizon_i);

  // one tap product per cycle
  logic signed [31:0] ca, cb;
  logic signed [63:0] prod;
  logic               ma_ok;
  logic [TW:0]        rix;
  always_comb begin
    ca = '0;
    cb = '0;
    rix = (TW+1)'(j_q) - (TW+1)'(step_q);
    ma_ok = (32'(j_q) >= 32'(step_q)) && (32'(j_q) < 32'(q_q));
    if (cmd_i.mac_ar) begin
      if (32'(j_q) < 32'(p_q)) begin
        ca = ar_q[j_q[$clog2(MAX_AR)-1:0]];
        cb = sc_q[j_q[$clog2(MAX_AR)-1:0]];
      end
    end else if (ma_ok) begin
      ca = ma_q[j_q[$clog2(MAX_MA)-1:0]];
      cb = rh_q[rix[$clog2(MAX_MA)-1:0]];
    end
    prod = ca * cb;
  end

  assign sts_o.tap_done = cmd_i.mac_ar ? (32'(j_q) + 1 >= 32'(p_q) || p_q == '0)
                                       : (32'(j_q) + 1 >= MAX_MA);
  assign sts_o.hz_zero = (hz_c == '0);
  assign sts_o.step_last = (32'(step_q) + 1 == 32'(hz_q));

  // bit-pair integer square root, one result bit per cycle
  logic [63:0] sv_q, sr_q, sb_q;
  logic        sbusy_q;
  logic [31:0] root;
  assign sts_o.sqrt_done = sbusy_q && (sb_q == '0);
  assign root = sr_q[31:0];

  logic signed [ACW-1:0] sat_src;
  logic signed [31:0]    pred_c;
  assign sat_src = acc_q;
  assign pred_c = (sat_src > ACW'(64'sd2147483647)) ? 32'sh7fffffff :
                  (sat_src < ACW'(-64'sd2147483648)) ? 32'sh80000000 : sat_src[31:0];

  logic [49:0] mprod;
  logic [33:0] margin;
  logic signed [34:0] lo, hi;
  assign mprod  = root * z_q;
  assign margin = 34'((mprod + 50'd32768) >> 16);
  assign lo = 35'(pred_q) - 35'(margin);
  assign hi = 35'(pred_q) + 35'(margin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_AR; i++) begin
        ar_q[i] <= '0;
        vh_q[i] <= '0;
      end
      for (int i = 0; i < MAX_MA; i++) begin
        ma_q[i] <= '0;
        rh_q[i] <= '0;
      end
      for (int i = 0; i < MAX_DIFF; i++) dm_q[i] <= '0;
      warm_q <= '0;
      step_q <= '0;
      hz_q <= '0;
      j_q <= '0;
      sbusy_q <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cmd_i.wr_ar && 32'(tap_index_i) < MAX_AR)
        ar_q[tap_index_i[$clog2(MAX_AR)-1:0]] <= sample_value_i;
      if (cmd_i.wr_ma && 32'(tap_index_i) < MAX_MA)
        ma_q[tap_index_i[$clog2(MAX_MA)-1:0]] <= sample_value_i;
      if (cmd_i.push) begin
        if (warm_q >= dsel) begin
          for (int i = MAX_AR - 1; i > 0; i--) vh_q[i] <= vh_q[i-1];
          vh_q[0] <= lv[dsel];
          for (int i = MAX_MA - 1; i > 0; i--) rh_q[i] <= rh_q[i-1];
          rh_q[0] <= sample_residual_i;
        end
        for (int k = 0; k < MAX_DIFF; k++)
          if (32'(warm_q) >= k) dm_q[k] <= lv[k];
        if (32'(warm_q) < MAX_DIFF) warm_q <= warm_q + 1'b1;
      end
      if (cmd_i.fc_init) begin
        for (int i = 0; i < MAX_AR; i++) sc_q[i] <= vh_q[i];
        p_q <= p_c;
        q_q <= q_c;
        hz_q <= hz_c;
        step_q <= '0;
        j_q <= '0;
        acc_q <= ACW'(intercept_i);
        z_q <= (confidence_mode_i == afi_pkg::MODE_99) ? afi_pkg::Z_99 :
               (confidence_mode_i == afi_pkg::MODE_90) ? afi_pkg::Z_90 : afi_pkg::Z_95;
      end
      if (cmd_i.mac_ar || cmd_i.mac_ma) begin
        acc_q <= acc_q + ACW'(prod >>> 16);
        j_q <= sts_o.tap_done ? '0 : j_q + 1'b1;
      end
      if (cmd_i.sqrt_start) begin
        sv_q <= (64'(noise_variance_i) * 64'(32'(step_q) + 1)) << 16;
        sr_q <= '0;
        sb_q <= 64'h4000_0000_0000_0000;
        sbusy_q <= 1'b1;
      end else if (sbusy_q && sb_q != '0) begin
        if (sv_q >= sr_q + sb_q) begin
          sv_q <= sv_q - (sr_q + sb_q);
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      if (cmd_i.finish) begin
        sbusy_q <= 1'b0;
        pred_q <= pred_c;
        for (int i = MAX_AR - 1; i > 0; i--) sc_q[i] <= sc_q[i-1];
        sc_q[0] <= pred_c;
      end
      if (cmd_i.emit) begin
        prediction_o <= pred_q;
        lower_bound_o <= (lo < -35'sd2147483648) ? 32'sh80000000 : lo[31:0];
        upper_bound_o <= (hi > 35'sd2147483647) ? 32'sh7fffffff : hi[31:0];
        step_ahead_o <= 6'(step_q);
        last_o <= sts_o.step_last;
        result_valid_o <= 1'b1;
        step_q <= step_q + 1'b1;
        acc_q <= ACW'(intercept_i);
      end
    end
  end

  a_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> sbusy_q && sb_q == '0) else $error("finish before root");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> 32'(step_ahead_o) < 32'(hz_q)) else $error("step past horizon");
  a_lb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> lower_bound_o <= upper_bound_o) else $error("bounds crossed");
endmodule

// ===== sv/arma_forecast_with_intervals.sv =====
`timescale 1ns / 1ps
// Top level of the ARMA forecaster with prediction intervals.
// Push and tap write: busy stays low. Forecast: per step the AR taps in use (one pass
// when none are in use), then all MAX_MA MA tap slots, then the bit-pair root, then
// finish and emit; each result shows the cycle after its emit cycle and the next
// request is taken after the last step. Results are strobed; no stall.
// Asynchronous active-low reset clears configuration registers, histories, taps and state.
module arma_forecast_with_intervals #(
  parameter int MAX_AR = 16,
  parameter int MAX_MA = 16,
  parameter int MAX_HORIZON = 64,
  parameter int MAX_DIFF = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         tap_index_i,
  input  logic signed [31:0] sample_value_i,
  input  logic signed [31:0] sample_residual_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [31:0] prediction_o,
  output logic signed [31:0] lower_bound_o,
  output logic signed [31:0] upper_bound_o,
  output logic [5:0]         step_ahead_o,
  output logic               last_o
);
  logic [4:0]  ar_order_q, ma_order_q;
  logic [1:0]  diff_order_q, mode_q;
  logic signed [31:0] intercept_q;
  logic [31:0] variance_q;
  logic [6:0]  horizon_q;
  afi_pkg::cmd_t cmd;
  afi_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ar_order_q <= '0;
      ma_order_q <= '0;
      diff_order_q <= '0;
      mode_q <= '0;
      intercept_q <= '0;
      variance_q <= '0;
      horizon_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        afi_pkg::REG_AR_ORDER:  ar_order_q <= cfg_data_i[4:0];
        afi_pkg::REG_MA_ORDER:  ma_order_q <= cfg_data_i[4:0];
        afi_pkg::REG_DIFF:      diff_order_q <= cfg_data_i[1:0];
        afi_pkg::REG_INTERCEPT: intercept_q <= cfg_data_i;
        afi_pkg::REG_VARIANCE:  variance_q <= cfg_data_i;
        afi_pkg::REG_HORIZON:   horizon_q <= cfg_data_i[6:0];
        afi_pkg::REG_MODE:      mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  afi_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .operation_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  afi_dp #(.MAX_AR(MAX_AR), .MAX_MA(MAX_MA), .MAX_HORIZON(MAX_HORIZON),
           .MAX_DIFF(MAX_DIFF)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .tap_index_i, .sample_value_i, .sample_residual_i,
    .ar_order_i(ar_order_q), .ma_order_i(ma_order_q), .diff_order_i(diff_order_q),
    .intercept_i(intercept_q), .noise_variance_i(variance_q),
    .horizon_i(horizon_q), .confidence_mode_i(mode_q),
    .prediction_o, .lower_bound_o, .upper_bound_o, .step_ahead_o, .last_o,
    .result_valid_o
  );
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the ARMA forecaster: directed table, then randomized phases.
module testbench;

  typedef struct {
    logic signed [31:0] pred;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [5:0]         step;
    logic               last;
  } fc_result_t;

  typedef struct {
    logic [1:0]         op;
    logic [3:0]         tap;
    logic [31:0]        val;
    logic [31:0]        res;
    bit                 typed;
    fc_result_t         want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] operation_i = afi_pkg::OP_PUSH;
  logic [3:0] tap_index_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic signed [31:0] sample_residual_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [31:0] prediction_o, lower_bound_o, upper_bound_o;
  logic [5:0] step_ahead_o;
  logic last_o;

  arma_forecast_with_intervals dut (.*);

  // model state
  logic [4:0] m_ar_order, m_ma_order;
  logic [1:0] m_diff, m_mode;
  logic signed [31:0] m_intercept;
  logic [31:0] m_variance;
  logic [6:0] m_horizon;
  logic signed [31:0] ar_coef[16], ma_coef[16], hist_val[16], hist_res[16], dmem[2];
  int warm;

  fc_result_t forecast_q[$];
  int errors = 0;
  int burst_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic mismatch(string msg);
    errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic model_reset();
    m_ar_order = 0; m_ma_order = 0; m_diff = 0; m_mode = 0;
    m_intercept = 0; m_variance = 0; m_horizon = 0; warm = 0;
    foreach (ar_coef[i]) begin
      ar_coef[i] = 0; ma_coef[i] = 0; hist_val[i] = 0; hist_res[i] = 0;
    end
    dmem[0] = 0; dmem[1] = 0;
  endtask

  task automatic model_push(logic signed [31:0] x, logic signed [31:0] r);
    logic signed [31:0] lv[3];
    int d;
    d = (m_diff > 2) ? 2 : m_diff;
    lv[0] = x;
    for (int k = 0; k < 2; k++) lv[k+1] = sat32(longint'(lv[k]) - longint'(dmem[k]));
    if (warm >= d) begin
      for (int i = 15; i > 0; i--) begin
        hist_val[i] = hist_val[i-1];
        hist_res[i] = hist_res[i-1];
      end
      hist_val[0] = lv[d];
      hist_res[0] = r;
    end
    for (int k = 0; k < 2; k++) if (warm >= k) dmem[k] = lv[k];
    if (warm < 2) warm++;
  endtask

  task automatic model_forecast();
    logic signed [31:0] scratch[16];
    int p, q, hz;
    longint acc, zq, margin;
    longint unsigned root;
    fc_result_t e;
    p = (m_ar_order > 16) ? 16 : m_ar_order;
    q = (m_ma_order > 16) ? 16 : m_ma_order;
    hz = (m_horizon > 64) ? 64 : m_horizon;
    zq = (m_mode == afi_pkg::MODE_99) ? longint'(afi_pkg::Z_99) :
         (m_mode == afi_pkg::MODE_90) ? longint'(afi_pkg::Z_90) : longint'(afi_pkg::Z_95);
    scratch = hist_val;
    for (int h = 0; h < hz; h++) begin
      acc = m_intercept;
      for (int j = 0; j < p; j++) acc += (longint'(ar_coef[j]) * longint'(scratch[j])) >>> 16;
      for (int j = h; j < q; j++)
        acc += (longint'(ma_coef[j]) * longint'(hist_res[j-h])) >>> 16;
      e.pred = sat32(acc);
      for (int i = 15; i > 0; i--) scratch[i] = scratch[i-1];
      scratch[0] = e.pred;
      root = isqrt((longint'(m_variance) * longint'(h + 1)) << 16);
      margin = (longint'(root) * zq + 32768) >>> 16;
      e.lo = sat32(longint'(e.pred) - margin);
      e.hi = sat32(longint'(e.pred) + margin);
      e.step = h[5:0];
      e.last = (h + 1 == hz);
      forecast_q.push_back(e);
    end
  endtask

  always @(posedge clk_i) begin
    fc_result_t e;
    if (rst_ni && result_valid_o) begin
      if (forecast_q.size() == 0) begin
        mismatch($sformatf("unexpected result pred=%0d step=%0d", prediction_o, step_ahead_o));
      end else begin
        e = forecast_q.pop_front();
        if (prediction_o !== e.pred || lower_bound_o !== e.lo || upper_bound_o !== e.hi ||
            step_ahead_o !== e.step || last_o !== e.last)
          mismatch($sformatf("got %0d/%0d/%0d h%0d l%0d want %0d/%0d/%0d h%0d l%0d",
            prediction_o, lower_bound_o, upper_bound_o, step_ahead_o, last_o,
            e.pred, e.lo, e.hi, e.step, e.last));
      end
    end
  end

  // waits for all results, then lets the block settle before a register write
  task automatic drain();
    int guard;
    guard = 0;
    start_i = 1'b0;
    burst_left = 0;
    while ((forecast_q.size() != 0 || busy_o) && guard < 400000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      afi_pkg::REG_AR_ORDER:  m_ar_order = data[4:0];
      afi_pkg::REG_MA_ORDER:  m_ma_order = data[4:0];
      afi_pkg::REG_DIFF:      m_diff = data[1:0];
      afi_pkg::REG_INTERCEPT: m_intercept = data;
      afi_pkg::REG_VARIANCE:  m_variance = data;
      afi_pkg::REG_HORIZON:   m_horizon = data[6:0];
      afi_pkg::REG_MODE:      m_mode = data[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(logic [4:0] p, logic [4:0] q, logic [1:0] d, logic [31:0] c,
                           logic [31:0] v, logic [6:0] hz, logic [1:0] mode);
    drain();
    cfg_write(afi_pkg::REG_AR_ORDER, p);
    cfg_write(afi_pkg::REG_MA_ORDER, q);
    cfg_write(afi_pkg::REG_DIFF, d);
    cfg_write(afi_pkg::REG_INTERCEPT, c);
    cfg_write(afi_pkg::REG_VARIANCE, v);
    cfg_write(afi_pkg::REG_HORIZON, hz);
    cfg_write(afi_pkg::REG_MODE, mode);
  endtask

  // issues one request; caller sits at a falling edge
  task automatic send(stim_row_t s);
    if (burst_left == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start_i = 1'b1;
    operation_i = s.op;
    tap_index_i = s.tap;
    sample_value_i = s.val;
    sample_residual_i = s.res;
    do @(posedge clk_i); while (busy_o);
    case (s.op)
      afi_pkg::OP_PUSH: model_push(s.val, s.res);
      afi_pkg::OP_AR:   ar_coef[s.tap] = s.val;
      afi_pkg::OP_MA:   ma_coef[s.tap] = s.val;
      default: begin
        if (s.typed) forecast_q.push_back(s.want);
        else model_forecast();
      end
    endcase
    @(negedge clk_i);
    if (burst_left == 0) start_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  task automatic random_phase(int n);
    stim_row_t s;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      s.typed = 0;
      s.tap = $urandom_range(0, 15);
      s.val = rand_value();
      s.res = rand_value();
      if (i < 3 || pick < 50) s.op = afi_pkg::OP_PUSH;
      else if (pick < 65) s.op = afi_pkg::OP_AR;
      else if (pick < 80) s.op = afi_pkg::OP_MA;
      else s.op = afi_pkg::OP_FC;
      send(s);
    end
  endtask

  stim_row_t table_rows[$];

  initial begin
    logic [6:0] hz;
    model_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unit variance, 95%: margin = 1.96 in Q16.16
    configure(5'd2, 5'd2, 2'd0, 32'h0001_0000, 32'h0001_0000, 7'd1, 2'd0);
    table_rows = '{
      '{afi_pkg::OP_FC,   4'd0,  32'h0,        32'h0,        1,
        '{32'sd65536, -32'sd62915, 32'sd193987, 6'd0, 1'b1}},
      '{afi_pkg::OP_AR,   4'd0,  32'h0000_8000, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_AR,   4'd1,  32'h8000_0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_AR,   4'd15, 32'h7fff_ffff, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_MA,   4'd0,  32'h0001_0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_MA,   4'd15, 32'h8000_0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_PUSH, 4'd0,  32'h7fff_ffff, 32'h8000_0000, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_PUSH, 4'd7,  32'h8000_0000, 32'h7fff_ffff, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_FC,   4'd0,  32'h0,        32'h0,        0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_PUSH, 4'd0,  32'h0,        32'h0,        0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_PUSH, 4'd0,  32'h0003_0000, 32'h0000_8000, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_AR,   4'd1,  32'h0000_4000, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_MA,   4'd1,  32'hffff_0000, 32'h0, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_FC,   4'd15, 32'hffff_ffff, 32'hffff_ffff, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_PUSH, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 0, '{0, 0, 0, 0, 0}},
      '{afi_pkg::OP_FC,   4'd0,  32'h0,        32'h0,        0, '{0, 0, 0, 0, 0}}
    };
    foreach (table_rows[i]) send(table_rows[i]);

    // extremes, then out-of-range orders, zero horizon and mode three
    configure(5'd16, 5'd16, 2'd2, 32'h8000_0000, 32'hffff_ffff, 7'd64, afi_pkg::MODE_99);
    random_phase(30);
    configure(5'd31, 5'd31, 2'd3, 32'h7fff_ffff, 32'h0, 7'd127, 2'd3);
    random_phase(20);
    configure(5'd0, 5'd0, 2'd1, 32'h0, 32'h0001_0000, 7'd0, afi_pkg::MODE_90);
    random_phase(15);

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 7))
        0: hz = 7'd64;
        1: hz = 7'($urandom_range(65, 127));
        2: hz = 7'd0;
        default: hz = 7'($urandom_range(1, 8));
      endcase
      configure($urandom_range(0, 5) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16)),
                $urandom_range(0, 5) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16)),
                2'($urandom_range(0, 3)), rand_value(),
                $urandom_range(0, 3) == 0 ? 32'h0 : $urandom(), hz, 2'($urandom_range(0, 3)));
      random_phase(58);
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
